@@ design/rar_pkg.sv @@
// rar_pkg: shared types and constants of the rational arithmetic reducer.
// Used by rar_ctrl, rar_dpath, the channel interfaces and the top level.
package rar_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // product selection for the shared multiplier
    localparam logic [1:0] MSEL_P0 = 2'd0;
    localparam logic [1:0] MSEL_P1 = 2'd1;
    localparam logic [1:0] MSEL_P2 = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_sel;
        logic       div_step;
        logic       keep_n;
        logic       out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic err;
        logic gcd_done;
    } t_stat;

endpackage

@@ design/rar_if.sv @@
// rar_if: valid/ready channel interfaces for operands and results.
// Depends on rar_pkg for the result field widths.
interface rar_in_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      cmd;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rar_pkg::NUM_W-1:0]   res_num;
    logic        [rar_pkg::DEN_W-1:0]   res_den;
    logic                               zero_den_error;

    modport source (output valid, res_num, res_den, zero_den_error, input ready);
    modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

@@ design/rar_ctrl.sv @@
// rar_ctrl: sequencer of the reducer; steps multiplies, gcd and divisions.
// Depends on rar_pkg for the command and status structs.
module rar_ctrl #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rar_pkg::t_stat i_stat,
    output rar_pkg::t_cmd  o_cmd
);

    localparam int MW = 2 * OPERAND_WIDTH + 1;
    localparam int CW = $clog2(MW + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_GINI = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_DIVN = 8'b0010_0000,
        S_DIVD = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[1:0];
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt[1:0] == rar_pkg::MSEL_P2) begin
                    n_state = i_stat.err ? S_DONE : S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_GINI;
            end
            S_GINI: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel  = 1'b0;
                    n_cnt          = '0;
                    n_state        = S_DIVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN: begin
                if (r_cnt == CW'(MW)) begin
                    o_cmd.keep_n   = 1'b1;
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel  = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end
            S_DIVD: begin
                if (r_cnt == CW'(MW)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold the result valid until the transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_fire_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_MUL))
        else $error("accepted operands did not start the multiply phase");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVN) || (r_state == S_DIVD)) |-> (r_cnt <= CW'(MW)))
        else $error("division step count overran");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

endmodule

@@ design/rar_dpath.sv @@
// rar_dpath: operand registers, shared multiplier, binary gcd and restoring divider.
// Depends on rar_pkg for command/status structs and result widths.
module rar_dpath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                              i_clk,
    input  rar_pkg::t_cmd                     i_cmd,
    output rar_pkg::t_stat                    o_stat,
    input  logic [1:0]                        i_op,
    input  logic signed [OPERAND_WIDTH-1:0]   i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]   i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]   i_b_den,
    output logic signed [rar_pkg::NUM_W-1:0]  o_res_num,
    output logic [rar_pkg::DEN_W-1:0]         o_res_den,
    output logic                              o_zero_den_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int KW = $clog2(MW + 1);
    localparam int NW = rar_pkg::NUM_W;
    localparam int DW = rar_pkg::DEN_W;

    logic signed [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic                 r_is_mul, r_is_sub, r_err;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic                 r_num_neg, r_den_neg;
    logic [MW-1:0]        r_nmag, r_dmag;
    logic [MW-1:0]        r_gx, r_gy;
    logic [KW-1:0]        r_k;
    logic [MW-1:0]        r_dq, r_rem, r_qn;

    logic signed [W-1:0]  mx, my;
    logic signed [PW-1:0] prod;
    logic signed [MW:0]   s0, s1, snum, sden;
    logic [MW:0]          anum, aden, dtrial;
    logic [MW-1:0]        gdiff_xy, gdiff_yx;
    logic                 qbit;
    logic [MW+NW-1:0]     ext_n, neg_n;
    logic [MW+DW-1:0]     ext_d;
    logic                 res_neg;

    assign o_stat.err      = r_err;
    assign o_stat.gcd_done = (r_gx == '0);

    // capture operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an     <= i_a_num;
            r_ad     <= i_a_den;
            r_bn     <= i_b_num;
            r_bd     <= i_b_den;
            r_is_mul <= i_op[1];
            r_is_sub <= (i_op == rar_pkg::OP_SUB);
            r_err    <= (i_a_den == '0) || (i_b_den == '0);
        end
    end

    // shared multiplier: one cross product per cycle
    always_comb begin
        mx = r_ad;
        my = r_bd;
        case (i_cmd.mul_sel)
            rar_pkg::MSEL_P0: begin
                mx = r_an;
                my = r_is_mul ? r_bn : r_bd;
            end
            rar_pkg::MSEL_P1: begin
                mx = r_bn;
                my = r_ad;
            end
            default: begin
                mx = r_ad;
                my = r_bd;
            end
        endcase
    end
    assign prod = mx * my;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rar_pkg::MSEL_P0: r_p0 <= prod;
                rar_pkg::MSEL_P1: r_p1 <= prod;
                default:          r_p2 <= prod;
            endcase
        end
    end

    // form the raw numerator and take magnitudes
    assign s0   = {{2{r_p0[PW-1]}}, r_p0};
    assign s1   = {{2{r_p1[PW-1]}}, r_p1};
    assign sden = {{2{r_p2[PW-1]}}, r_p2};
    assign snum = r_is_mul ? s0 : (r_is_sub ? (s0 - s1) : (s0 + s1));
    assign anum = snum[MW] ? (-snum) : snum;
    assign aden = sden[MW] ? (-sden) : sden;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_num_neg <= snum[MW];
            r_den_neg <= sden[MW];
            r_nmag    <= anum[MW-1:0];
            r_dmag    <= aden[MW-1:0];
        end
    end

    // binary gcd, one step per cycle; gcd = r_gy << r_k when r_gx reaches zero
    assign gdiff_xy = r_gx - r_gy;
    assign gdiff_yx = r_gy - r_gx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_gx <= r_nmag;
            r_gy <= r_dmag;
            r_k  <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_k  <= r_k + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= gdiff_xy >> 1;
            end else begin
                r_gy <= gdiff_yx >> 1;
            end
        end
    end

    // restoring divider by the odd part of the gcd, dividend pre-shifted by r_k
    assign dtrial = {r_rem, r_dq[MW-1]};
    assign qbit   = (dtrial >= {1'b0, r_gy});

    always_ff @(posedge i_clk) begin
        if (i_cmd.keep_n) begin
            r_qn <= r_dq;
        end
        if (i_cmd.div_init) begin
            r_dq  <= (i_cmd.div_sel ? r_dmag : r_nmag) >> r_k;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[MW-2:0], qbit};
            r_rem <= qbit ? MW'(dtrial - {1'b0, r_gy}) : dtrial[MW-1:0];
        end
    end

    // result register: sign onto the numerator
    assign res_neg = (r_qn != '0) && (r_num_neg != r_den_neg);
    assign ext_n   = {{NW{1'b0}}, r_qn};
    assign neg_n   = -ext_n;
    assign ext_d   = {{DW{1'b0}}, r_dq};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_err) begin
                o_res_num        <= '0;
                o_res_den        <= '0;
                o_zero_den_error <= 1'b1;
            end else begin
                o_res_num        <= res_neg ? neg_n[NW-1:0] : ext_n[NW-1:0];
                o_res_den        <= ext_d[DW-1:0];
                o_zero_den_error <= 1'b0;
            end
        end
    end

endmodule

@@ design/rational_arith_reduce.sv @@
// rational_arith_reduce: top level of the rational add/subtract/multiply reducer.
// Depends on rar_pkg, rar_if, rar_ctrl and rar_dpath.
//
//  Port        Dir   Payload                                   Transfer
//  i_in_chan   sink  cmd, a_num, a_den, b_num, b_den           valid & ready
//  o_out_chan  src   res_num, res_den, zero_den_error          valid & ready
//
// One item at a time: three multiplies, sum, gcd setup, the binary gcd loop with
// its finish check, and two restoring divisions of MW = 2*OPERAND_WIDTH+1 bits,
// then the result load. A zero denominator skips to the result after the
// multiplies. Reset is synchronous, active low, and clears the sequencer only.
// A new item is taken while a result waits.
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rar_in_if.sink  i_in_chan,
    rar_out_if.source o_out_chan
);

    rar_pkg::t_cmd  cmd;
    rar_pkg::t_stat stat;

    rar_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_chan.valid),
        .o_in_ready  (i_in_chan.ready),
        .o_out_valid (o_out_chan.valid),
        .i_out_ready (o_out_chan.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rar_dpath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_in_chan.cmd),
        .i_a_num          (i_in_chan.a_num),
        .i_a_den          (i_in_chan.a_den),
        .i_b_num          (i_in_chan.b_num),
        .i_b_den          (i_in_chan.b_den),
        .o_res_num        (o_out_chan.res_num),
        .o_res_den        (o_out_chan.res_den),
        .o_zero_den_error (o_out_chan.zero_den_error)
    );

endmodule
